[src/cdq_pkg.sv]
// types and codes shared by the circular deque modules
`timescale 1ns / 1ps
package cdq_pkg;

  // word width of one stored element
  localparam int unsigned DataW = 32;

  // operation codes
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP_FINISH
  } state_t;

  // input word
  typedef struct packed {
    op_t                     op;
    logic signed [DataW-1:0] push_value;
  } item_t;

  // result word
  typedef struct packed {
    status_t                 status;
    logic signed [DataW-1:0] popped_value;
    logic                    now_empty;
    logic                    now_full;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch_item;
    logic execute;
    logic finish_pop;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pop_read;
  } stat_t;

endpackage

[src/cdq_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/cdq_ctrl.sv]
// controller state machine for the circular deque
`timescale 1ns / 1ps
module cdq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cdq_pkg::stat_t stat,
  output logic          busy,
  output logic          done,
  output cdq_pkg::cmd_t cmd
);

  cdq_pkg::state_t state;
  cdq_pkg::state_t state_next;
  logic            done_next;

  // state register and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdq_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cdq_pkg::S_IDLE: begin
        if (start) begin
          state_next = cdq_pkg::S_EXEC;
        end
      end
      cdq_pkg::S_EXEC: begin
        if (stat.pop_read) begin
          state_next = cdq_pkg::S_POP_FINISH;
        end else begin
          state_next = cdq_pkg::S_IDLE;
        end
      end
      cdq_pkg::S_POP_FINISH: begin
        state_next = cdq_pkg::S_IDLE;
      end
      default: begin
        state_next = cdq_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    busy           = 1'b1;
    done_next      = 1'b0;
    cmd.latch_item = 1'b0;
    cmd.execute    = 1'b0;
    cmd.finish_pop = 1'b0;
    case (state)
      cdq_pkg::S_IDLE: begin
        busy           = 1'b0;
        cmd.latch_item = start;
      end
      cdq_pkg::S_EXEC: begin
        cmd.execute = 1'b1;
        done_next   = !stat.pop_read;
      end
      cdq_pkg::S_POP_FINISH: begin
        cmd.finish_pop = 1'b1;
        done_next      = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

[src/cdq_datapath.sv]
// indices, element store and result register of the circular deque
`timescale 1ns / 1ps
module cdq_datapath #(
  parameter int unsigned DEPTH = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  cdq_pkg::item_t   item,
  input  cdq_pkg::cmd_t    cmd,
  output cdq_pkg::stat_t   stat,
  output cdq_pkg::result_t result
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  cdq_pkg::item_t item_q;
  logic [AW-1:0]  front;
  logic [AW-1:0]  rear;
  logic           empty;
  logic [AW-1:0]  front_next;
  logic [AW-1:0]  rear_next;
  logic           empty_next;
  logic [AW-1:0]  front_inc;
  logic [AW-1:0]  front_dec;
  logic [AW-1:0]  rear_inc;
  logic [AW-1:0]  rear_dec;
  logic [AW-1:0]  rear_next_inc;
  logic           is_push;
  logic           is_full;
  logic           we;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;
  logic [cdq_pkg::DataW-1:0] rdata;
  cdq_pkg::status_t status_w;

  // wrapped neighbours of the indices
  assign front_inc = (front == LastIdx) ? '0 : front + 1'b1;
  assign front_dec = (front == '0) ? LastIdx : front - 1'b1;
  assign rear_inc  = (rear == LastIdx) ? '0 : rear + 1'b1;
  assign rear_dec  = (rear == '0) ? LastIdx : rear - 1'b1;

  assign is_push = (item_q.op == cdq_pkg::OP_PUSH_FRONT) ||
                   (item_q.op == cdq_pkg::OP_PUSH_REAR);
  assign is_full = !empty && (rear_inc == front);

  // operation decode and index update
  always_comb begin
    front_next = front;
    rear_next  = rear;
    empty_next = empty;
    we         = 1'b0;
    waddr      = '0;
    status_w   = cdq_pkg::ST_DONE;
    stat.pop_read = 1'b0;
    if (is_push) begin
      if (is_full) begin
        status_w = cdq_pkg::ST_FULL;
      end else if (empty) begin
        front_next = '0;
        rear_next  = '0;
        empty_next = 1'b0;
        we         = cmd.execute;
      end else if (item_q.op == cdq_pkg::OP_PUSH_FRONT) begin
        front_next = front_dec;
        waddr      = front_dec;
        we         = cmd.execute;
      end else begin
        rear_next = rear_inc;
        waddr     = rear_inc;
        we        = cmd.execute;
      end
    end else begin
      if (empty) begin
        status_w = cdq_pkg::ST_EMPTY;
      end else begin
        stat.pop_read = 1'b1;
        if (front == rear) begin
          front_next = '0;
          rear_next  = '0;
          empty_next = 1'b1;
        end else if (item_q.op == cdq_pkg::OP_POP_FRONT) begin
          front_next = front_inc;
        end else begin
          rear_next = rear_dec;
        end
      end
    end
  end

  assign raddr = (item_q.op == cdq_pkg::OP_POP_FRONT) ? front : rear;
  assign rear_next_inc = (rear_next == LastIdx) ? '0 : rear_next + 1'b1;

  // element store
  cdq_ram #(
    .WIDTH(cdq_pkg::DataW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(item_q.push_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  // indices and empty flag
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      rear  <= '0;
      empty <= 1'b1;
    end else if (cmd.execute) begin
      front <= front_next;
      rear  <= rear_next;
      empty <= empty_next;
    end
  end

  // input word and result word
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_q <= item;
    end
    if (cmd.execute) begin
      result.status       <= status_w;
      result.popped_value <= '0;
      result.now_empty    <= empty_next;
      result.now_full     <= !empty_next && (rear_next_inc == front_next);
    end
    if (cmd.finish_pop) begin
      result.popped_value <= rdata;
    end
  end

endmodule

[src/circular_deque_unit.sv]
// circular deque: top level joining controller and datapath
// an accepted word passes through the execute state before its done strobe; a
// successful pop also passes through the pop-finish state for the store read port
// a new word is taken only when idle: busy is high until the word is done
// reset clears the indices and sets the empty flag; the store is not cleared
// each result shows for one cycle with done high; the receiver cannot stall
`timescale 1ns / 1ps
module circular_deque_unit #(
  parameter int unsigned DEPTH = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cdq_pkg::item_t   item,
  output logic             busy,
  output logic             done,
  output cdq_pkg::result_t result
);

  cdq_pkg::cmd_t  cmd;
  cdq_pkg::stat_t stat;

  // controller
  cdq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .busy (busy),
    .done (done),
    .cmd  (cmd)
  );

  // datapath
  cdq_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .cmd   (cmd),
    .stat  (stat),
    .result(result)
  );

endmodule

[dv/circular_deque_unit_test.sv]
// self-checking testbench for the circular deque unit
`timescale 1ns / 1ps
module circular_deque_unit_test;

  localparam int unsigned Depth       = 128;
  localparam int unsigned RandomWords = 1200;
  localparam int unsigned MaxGap      = 12;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 200000;

  // push percentage per burst: fill-biased, drain-biased, balanced
  localparam int unsigned PushPct [3] = '{85, 15, 50};

  // one directed word with an optional hand-written expectation
  typedef struct packed {
    cdq_pkg::item_t   w;
    logic             typed;
    cdq_pkg::result_t r;
  } stim_row_t;

  localparam cdq_pkg::result_t NoRes = '0;

  localparam stim_row_t DirectedRows [21] = '{
    '{'{cdq_pkg::OP_POP_FRONT, 32'sh1234_5678}, 1'b1,
      '{cdq_pkg::ST_EMPTY, 32'sh0, 1'b1, 1'b0}},
    '{'{cdq_pkg::OP_POP_REAR, 32'shffff_ffff}, 1'b1,
      '{cdq_pkg::ST_EMPTY, 32'sh0, 1'b1, 1'b0}},
    '{'{cdq_pkg::OP_PUSH_FRONT, 32'sh7fff_ffff}, 1'b1,
      '{cdq_pkg::ST_DONE, 32'sh0, 1'b0, 1'b0}},
    '{'{cdq_pkg::OP_POP_REAR, 32'sh0}, 1'b1,
      '{cdq_pkg::ST_DONE, 32'sh7fff_ffff, 1'b1, 1'b0}},
    '{'{cdq_pkg::OP_PUSH_REAR, 32'sh8000_0000}, 1'b1,
      '{cdq_pkg::ST_DONE, 32'sh0, 1'b0, 1'b0}},
    '{'{cdq_pkg::OP_POP_FRONT, 32'sh0}, 1'b1,
      '{cdq_pkg::ST_DONE, 32'sh8000_0000, 1'b1, 1'b0}},
    '{'{cdq_pkg::OP_PUSH_FRONT, 32'sh0}, 1'b1,
      '{cdq_pkg::ST_DONE, 32'sh0, 1'b0, 1'b0}},
    '{'{cdq_pkg::OP_PUSH_FRONT, 32'shffff_ffff}, 1'b0, NoRes},
    '{'{cdq_pkg::OP_PUSH_REAR,  32'sh5555_5555}, 1'b0, NoRes},
    '{'{cdq_pkg::OP_PUSH_FRONT, 32'shaaaa_aaaa}, 1'b0, NoRes},
    '{'{cdq_pkg::OP_POP_FRONT,  32'sha5a5_a5a5}, 1'b0, NoRes},
    '{'{cdq_pkg::OP_POP_REAR,   32'sh5a5a_5a5a}, 1'b0, NoRes},
    '{'{cdq_pkg::OP_POP_REAR,   32'sh0},         1'b0, NoRes},
    '{'{cdq_pkg::OP_POP_FRONT,  32'sh0},         1'b0, NoRes},
    '{'{cdq_pkg::OP_POP_REAR, 32'sh0}, 1'b1,
      '{cdq_pkg::ST_EMPTY, 32'sh0, 1'b1, 1'b0}},
    '{'{cdq_pkg::OP_PUSH_REAR, 32'sh1}, 1'b1,
      '{cdq_pkg::ST_DONE, 32'sh0, 1'b0, 1'b0}},
    '{'{cdq_pkg::OP_PUSH_REAR,  32'sh2},         1'b0, NoRes},
    '{'{cdq_pkg::OP_PUSH_FRONT, 32'sh3},         1'b0, NoRes},
    '{'{cdq_pkg::OP_POP_REAR,   32'sh0},         1'b0, NoRes},
    '{'{cdq_pkg::OP_POP_FRONT,  32'sh0},         1'b0, NoRes},
    '{'{cdq_pkg::OP_POP_FRONT,  32'sh0},         1'b0, NoRes}
  };

  logic             clk   = 1'b0;
  logic             rst   = 1'b1;
  logic             start = 1'b0;
  cdq_pkg::item_t   item  = '0;
  logic             busy;
  logic             done;
  cdq_pkg::result_t result;

  circular_deque_unit #(
    .DEPTH(Depth)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  // mirror of the deque contents and indices
  logic signed [cdq_pkg::DataW-1:0] mirror_store [Depth];
  int unsigned                      mirror_front = 0;
  int unsigned                      mirror_rear  = 0;
  bit                               mirror_empty = 1'b1;

  cdq_pkg::result_t pending_results [$];
  int unsigned      err_count   = 0;
  int unsigned      cycle_count = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned next_slot(input int unsigned i);
    return (i + 1 >= Depth) ? 0 : i + 1;
  endfunction

  function automatic int unsigned prev_slot(input int unsigned i);
    return (i == 0) ? Depth - 1 : i - 1;
  endfunction

  function automatic bit mirror_full();
    return !mirror_empty && next_slot(mirror_rear) == mirror_front;
  endfunction

  // apply one word to the mirror and return the result it should give
  function automatic cdq_pkg::result_t deque_predict(input cdq_pkg::item_t w);
    cdq_pkg::result_t r;
    r.status       = cdq_pkg::ST_DONE;
    r.popped_value = '0;
    if (w.op == cdq_pkg::OP_PUSH_FRONT || w.op == cdq_pkg::OP_PUSH_REAR) begin
      if (mirror_full()) begin
        r.status = cdq_pkg::ST_FULL;
      end else if (mirror_empty) begin
        // first element always lands in slot zero
        mirror_front    = 0;
        mirror_rear     = 0;
        mirror_empty    = 1'b0;
        mirror_store[0] = w.push_value;
      end else if (w.op == cdq_pkg::OP_PUSH_FRONT) begin
        mirror_front               = prev_slot(mirror_front);
        mirror_store[mirror_front] = w.push_value;
      end else begin
        mirror_rear               = next_slot(mirror_rear);
        mirror_store[mirror_rear] = w.push_value;
      end
    end else begin
      if (mirror_empty) begin
        r.status = cdq_pkg::ST_EMPTY;
      end else begin
        r.popped_value = (w.op == cdq_pkg::OP_POP_FRONT) ? mirror_store[mirror_front]
                                                         : mirror_store[mirror_rear];
        // removing the last element resets both indices
        if (mirror_front == mirror_rear) begin
          mirror_front = 0;
          mirror_rear  = 0;
          mirror_empty = 1'b1;
        end else if (w.op == cdq_pkg::OP_POP_FRONT) begin
          mirror_front = next_slot(mirror_front);
        end else begin
          mirror_rear = prev_slot(mirror_rear);
        end
      end
    end
    r.now_empty = mirror_empty;
    r.now_full  = mirror_full();
    return r;
  endfunction

  // present one word after an optional idle gap and wait until busy drops
  task automatic send_word(input cdq_pkg::item_t w, input int unsigned gap,
                           input bit typed, input cdq_pkg::result_t typed_r);
    cdq_pkg::result_t predicted;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= w;
    do @(posedge clk); while (busy);
    predicted = deque_predict(w);
    pending_results.push_back(typed ? typed_r : predicted);
  endtask

  // stimulus: directed table, then bursts biased towards filling or draining, or balanced
  initial begin : stimulus
    cdq_pkg::item_t w;
    int unsigned    sent;
    int unsigned    push_pct;
    int unsigned    burst_len;
    int unsigned    k;
    bit             quiet;
    bit             is_push;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < $size(DirectedRows); k++) begin
      send_word(DirectedRows[k].w, $urandom_range(0, MaxGap), DirectedRows[k].typed,
                DirectedRows[k].r);
    end

    sent = 0;
    while (sent < RandomWords) begin
      push_pct  = PushPct[$urandom_range(0, 2)];
      burst_len = $urandom_range(40, 300);
      quiet     = ($urandom_range(0, 3) == 0);
      for (k = 0; k < burst_len && sent < RandomWords; k++) begin
        is_push      = ($urandom_range(0, 99) < push_pct);
        if (is_push) begin
          w.op = $urandom_range(0, 1) ? cdq_pkg::OP_PUSH_REAR : cdq_pkg::OP_PUSH_FRONT;
        end else begin
          w.op = $urandom_range(0, 1) ? cdq_pkg::OP_POP_REAR : cdq_pkg::OP_POP_FRONT;
        end
        w.push_value = $urandom;
        send_word(w, quiet ? 0 : $urandom_range(0, MaxGap), 1'b0, NoRes);
        sent++;
      end
    end
    start <= 1'b0;

    // let the last results arrive, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS circular_deque_unit");
    end else begin
      $display("FAIL circular_deque_unit");
    end
    $finish;
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin : result_check
    cdq_pkg::result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result word with none expected: status %0d popped %h",
               result.status, result.popped_value);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          err_count++;
        end
        if (result.popped_value !== want.popped_value) begin
          $error("popped_value: expected %h, got %h", want.popped_value,
                 result.popped_value);
          err_count++;
        end
        if (result.now_empty !== want.now_empty) begin
          $error("now_empty: expected %b, got %b", want.now_empty, result.now_empty);
          err_count++;
        end
        if (result.now_full !== want.now_full) begin
          $error("now_full: expected %b, got %b", want.now_full, result.now_full);
          err_count++;
        end
      end
    end
  end

  // hang guard
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL circular_deque_unit");
      $finish;
    end
  end

endmodule
